// File: sv/source_text_tokenizer_unit_assert.svh
// Assertion macros for the source text tokenizer.
// Expects clk and arst_n in the scope of use.
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/stt_pkg.sv
// Shared types, constants and character helpers for the source text tokenizer.
// No dependencies.
package stt_pkg;

	localparam int POSITION_BITS = 32;
	localparam int LENGTH_BITS   = 16;
	localparam int KEYWORD_BYTES = 6;
	localparam int KW_IDX_BITS   = $clog2(KEYWORD_BYTES);
	localparam int KW_COUNT      = 6;
	localparam int KW_MAX_LEN    = 6;
	localparam int PUNCT_COUNT   = 12;
	localparam int RES_DEPTH     = 4;
	localparam int RES_PTR_BITS  = $clog2(RES_DEPTH);
	localparam int RES_CNT_BITS  = $clog2(RES_DEPTH + 1);

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [LENGTH_BITS-1:0] len_t;
	typedef logic [4:0] kind_t;
	typedef logic [KEYWORD_BYTES-1:0][7:0] kwbuf_t;

	localparam kind_t KIND_EOF     = 5'd0;
	localparam kind_t KIND_KW_BASE = 5'd1;
	localparam kind_t KIND_IDENT   = 5'd7;
	localparam kind_t KIND_NUMBER  = 5'd8;
	localparam kind_t KIND_STRING  = 5'd9;
	localparam kind_t KIND_PUNCT   = 5'd10;
	localparam kind_t KIND_UNKNOWN = 5'd22;
	localparam kind_t KIND_UNTERM  = 5'd23;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00},
		'{"s", "t", "r", "i", "n", "g"},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00},
		'{"p", "r", "i", "n", "t", 8'h00}
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd6, 3'd2, 3'd4, 3'd5, 3'd5};
	localparam logic [7:0] PUNCT [PUNCT_COUNT] = '{
		"+", "-", "*", "/", "=", ">", "<", "(", ")", "{", "}", ";"
	};

	typedef enum logic [7:0] {
		M_IDLE     = 8'b0000_0001,
		M_COMMENT  = 8'b0000_0010,
		M_NUMBER   = 8'b0000_0100,
		M_IDENT    = 8'b0000_1000,
		M_STRING   = 8'b0001_0000,
		M_SINGLE   = 8'b0010_0000,
		M_DONE     = 8'b0100_0000,
		M_EOF_HELD = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_last;
	} in_t;

	typedef struct packed {
		kind_t kind;
		pos_t  start;
		len_t  length;
		logic  last;
	} tok_t;

	typedef struct packed {
		logic [1:0] n;
		tok_t       r0;
		tok_t       r1;
	} push_t;

	typedef struct packed {
		logic  any;
		kind_t kind;
	} close_t;

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
	endfunction

	function automatic logic is_word(logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == CH_UNDER;
	endfunction

	function automatic kind_t ident_kind(len_t len, kwbuf_t kw);
		kind_t res;
		logic  hit;
		res = KIND_IDENT;
		if (len <= len_t'(KEYWORD_BYTES)) begin
			for (int k = 0; k < KW_COUNT; k++) begin
				hit = (len == len_t'(KW_LEN[k]));
				for (int i = 0; i < KW_MAX_LEN; i++) begin
					if (i < int'(KW_LEN[k]) && kw[i] != KW_TEXT[k][i])
						hit = 1'b0;
				end
				if (hit && res == KIND_IDENT)
					res = KIND_KW_BASE + kind_t'(k);
			end
		end
		return res;
	endfunction

	function automatic kind_t single_kind(logic [7:0] c);
		kind_t res;
		res = KIND_UNKNOWN;
		for (int k = 0; k < PUNCT_COUNT; k++) begin
			if (PUNCT[k] == c)
				res = KIND_PUNCT + kind_t'(k);
		end
		return res;
	endfunction

	function automatic close_t close_kind(mode_t m, len_t len, kwbuf_t kw);
		close_t res;
		res = '{any: 1'b1, kind: KIND_EOF};
		unique case (m)
			M_NUMBER: res.kind = KIND_NUMBER;
			M_IDENT:  res.kind = ident_kind(len, kw);
			M_SINGLE: res.kind = single_kind(kw[0]);
			M_STRING: res.kind = KIND_UNTERM;
			default:  res.any = 1'b0;
		endcase
		return res;
	endfunction

endpackage

// File: sv/stt_src_if.sv
// Source byte channel for the tokenizer.
// Does not depend on stt_pkg; its widths are written out here.
interface stt_src_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       is_last;

	modport source(output valid, data_byte, has_byte, is_last, input ready);
	modport sink(input valid, data_byte, has_byte, is_last, output ready);
endinterface

// File: sv/stt_tok_if.sv
// Token record channel out of the tokenizer.
// Field types come from stt_pkg.
interface stt_tok_if;
	logic           valid;
	logic           ready;
	stt_pkg::kind_t token_kind;
	stt_pkg::pos_t  token_start;
	stt_pkg::len_t  token_length;
	logic           last_of_run;

	modport source(output valid, token_kind, token_start, token_length, last_of_run,
		input ready);
	modport sink(input valid, token_kind, token_start, token_length, last_of_run,
		output ready);
endinterface

// File: sv/source_text_tokenizer_unit.sv
// Source text tokenizer: one source byte per item in, token records out
// (kind, start offset, length). An item is taken every cycle while the
// 4-entry result queue has two free entries; the scanner state updates in the
// cycle the item is taken and its records enter the queue at that edge, so a
// record can be taken out the next cycle. Records leave one per cycle while
// tok.ready is high; an item that closes a token and ends the source queues
// two records. After end-of-file, items are taken and dropped until reset.
// Depends on stt_pkg, stt_src_if, stt_tok_if, stt_core, stt_res_fifo.
`include "source_text_tokenizer_unit_assert.svh"

module source_text_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	stt_src_if.sink    src,
	stt_tok_if.source  tok
);

	stt_pkg::in_t   item;
	stt_pkg::push_t push;
	logic           room;
	logic           accept;

	assign item.data_byte = src.data_byte;
	assign item.has_byte  = src.has_byte;
	assign item.is_last   = src.is_last;
	assign src.ready      = room;
	assign accept         = src.valid && room;

	stt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.accept (accept),
		.push   (push)
	);

	stt_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tok    (tok)
	);

	`STT_ASSERT_IMP(a_push_needs_item, push.n != 2'd0, accept, "records without an item")
	`STT_ASSERT_IMP(a_single_last, push.n == 2'd1, push.r0.last, "lone record not last")
	`STT_ASSERT_IMP(a_pair_last, push.n == 2'd2, push.r1.last && !push.r0.last,
		"record pair last flag wrong")
	`STT_ASSERT_NEXT(a_push_visible, push.n != 2'd0, tok.valid, "queued record not shown")

endmodule

// File: sv/stt_core.sv
// Scanner state and per-item next-state/record logic of the tokenizer.
// Depends on stt_pkg.
module stt_core (
	input  logic          clk,
	input  logic          arst_n,
	input  stt_pkg::in_t  item,
	input  logic          accept,
	output stt_pkg::push_t push
);

	stt_pkg::mode_t  mode_q, mode_n;
	stt_pkg::pos_t   pos_q, pos_n;
	stt_pkg::pos_t   start_q, start_n;
	stt_pkg::len_t   len_q, len_n, len_sat;
	stt_pkg::kwbuf_t kw_q, kw_n;
	stt_pkg::close_t cl;
	stt_pkg::tok_t   rec, r0, r1;
	logic [1:0]      n;
	logic [7:0]      c;
	logic            ended, restart;

	assign c       = item.data_byte;
	assign len_sat = (len_q != '1) ? len_q + stt_pkg::len_t'(1) : len_q;

	always_comb begin
		mode_n  = mode_q;
		pos_n   = pos_q;
		start_n = start_q;
		len_n   = len_q;
		kw_n    = kw_q;
		ended   = 1'b0;
		restart = 1'b0;
		n       = 2'd0;
		r0      = '0;
		r1      = '0;
		rec     = '0;
		cl      = '0;
		unique case (mode_q)
			stt_pkg::M_DONE: begin
			end
			stt_pkg::M_EOF_HELD: begin
				r0     = '{kind: stt_pkg::KIND_EOF, start: pos_q, length: '0, last: 1'b0};
				n      = 2'd1;
				mode_n = stt_pkg::M_DONE;
			end
			default: begin
				if (item.has_byte) begin
					if (c == stt_pkg::CH_NUL) begin
						ended = 1'b1;
					end else begin
						unique case (mode_q)
							stt_pkg::M_COMMENT: begin
								if (c == stt_pkg::CH_NL)
									mode_n = stt_pkg::M_IDLE;
							end
							stt_pkg::M_STRING: begin
								if (c == stt_pkg::CH_QUOTE) begin
									r0 = '{kind: stt_pkg::KIND_STRING, start: start_q,
										length: len_q, last: 1'b0};
									n      = 2'd1;
									mode_n = stt_pkg::M_IDLE;
								end else begin
									len_n = len_sat;
								end
							end
							stt_pkg::M_NUMBER: begin
								if (stt_pkg::is_digit(c))
									len_n = len_sat;
								else
									restart = 1'b1;
							end
							stt_pkg::M_IDENT: begin
								if (stt_pkg::is_word(c)) begin
									if (len_q < stt_pkg::len_t'(stt_pkg::KEYWORD_BYTES))
										kw_n[len_q[stt_pkg::KW_IDX_BITS-1:0]] = c;
									len_n = len_sat;
								end else begin
									restart = 1'b1;
								end
							end
							default: restart = 1'b1;
						endcase
						if (restart) begin
							cl = stt_pkg::close_kind(mode_q, len_q, kw_q);
							if (cl.any) begin
								r0 = '{kind: cl.kind, start: start_q, length: len_q, last: 1'b0};
								n  = 2'd1;
							end
							mode_n = stt_pkg::M_IDLE;
							if (stt_pkg::is_space(c)) begin
							end else if (c == stt_pkg::CH_HASH) begin
								mode_n = stt_pkg::M_COMMENT;
							end else begin
								start_n = pos_q;
								len_n   = stt_pkg::len_t'(1);
								if (stt_pkg::is_digit(c)) begin
									mode_n = stt_pkg::M_NUMBER;
								end else if (stt_pkg::is_alpha(c) || c == stt_pkg::CH_UNDER) begin
									kw_n    = '0;
									kw_n[0] = c;
									mode_n  = stt_pkg::M_IDENT;
								end else if (c == stt_pkg::CH_QUOTE) begin
									start_n = pos_q + stt_pkg::pos_t'(1);
									len_n   = '0;
									mode_n  = stt_pkg::M_STRING;
								end else begin
									kw_n[0] = c;
									mode_n  = stt_pkg::M_SINGLE;
								end
							end
						end
						pos_n = pos_q + stt_pkg::pos_t'(1);
					end
				end
				if (item.is_last)
					ended = 1'b1;
				if (ended) begin
					cl = stt_pkg::close_kind(mode_n, len_n, kw_n);
					if (cl.any) begin
						rec = '{kind: cl.kind, start: start_n, length: len_n, last: 1'b0};
						if (n == 2'd0)
							r0 = rec;
						else
							r1 = rec;
						n = n + 2'd1;
					end
					if (n < 2'd2) begin
						rec = '{kind: stt_pkg::KIND_EOF, start: pos_n, length: '0, last: 1'b0};
						if (n == 2'd0)
							r0 = rec;
						else
							r1 = rec;
						n      = n + 2'd1;
						mode_n = stt_pkg::M_DONE;
					end else begin
						mode_n = stt_pkg::M_EOF_HELD;
					end
				end
			end
		endcase
		if (n == 2'd1)
			r0.last = 1'b1;
		if (n == 2'd2)
			r1.last = 1'b1;
	end

	assign push.n  = accept ? n : 2'd0;
	assign push.r0 = r0;
	assign push.r1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stt_pkg::M_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			kw_q    <= '0;
		end else if (accept) begin
			mode_q  <= mode_n;
			pos_q   <= pos_n;
			start_q <= start_n;
			len_q   <= len_n;
			kw_q    <= kw_n;
		end
	end

endmodule

// File: sv/stt_res_fifo.sv
// Result queue: takes up to two token records per cycle, hands out one while tok.ready is high.
// Depends on stt_pkg and stt_tok_if.
module stt_res_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  stt_pkg::push_t push,
	output logic           room,
	stt_tok_if.source      tok
);

	stt_pkg::tok_t mem [stt_pkg::RES_DEPTH];
	logic [stt_pkg::RES_PTR_BITS-1:0] wr_q, rd_q;
	logic [stt_pkg::RES_CNT_BITS-1:0] cnt_q;
	logic pop;

	assign room = cnt_q <= stt_pkg::RES_CNT_BITS'(stt_pkg::RES_DEPTH - 2);
	assign pop  = tok.valid && tok.ready;

	assign tok.valid        = cnt_q != '0;
	assign tok.token_kind   = mem[rd_q].kind;
	assign tok.token_start  = mem[rd_q].start;
	assign tok.token_length = mem[rd_q].length;
	assign tok.last_of_run  = mem[rd_q].last;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem[wr_q] <= push.r0;
		if (push.n == 2'd2)
			mem[wr_q + stt_pkg::RES_PTR_BITS'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + stt_pkg::RES_PTR_BITS'(push.n);
			if (pop)
				rd_q <= rd_q + stt_pkg::RES_PTR_BITS'(1);
			cnt_q <= cnt_q + stt_pkg::RES_CNT_BITS'(push.n)
				- stt_pkg::RES_CNT_BITS'(pop);
		end
	end

endmodule
